>>> rtl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Command codes, register indexes, field widths and the structs that move
// between the front end, the queue and the sequencing engine.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int LONG_W   = 10;
    localparam int SHORT_W  = 8;
    localparam int INDEX_W  = 4;
    localparam int REGIDX_W = 3;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROM    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PULLUP = 3'd5;

    // Configuration register indexes
    localparam logic [REGIDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_SHORT_SLOT    = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_LONG_SLOT     = 3'd4;

    // Register reset values
    localparam logic [LONG_W-1:0]  RESET_LOW_DEFAULT     = 10'd500;
    localparam logic [SHORT_W-1:0] PRESENCE_WAIT_DEFAULT = 8'd70;
    localparam logic [LONG_W-1:0]  RESET_TAIL_DEFAULT    = 10'd500;
    localparam logic [SHORT_W-1:0] SHORT_SLOT_DEFAULT    = 8'd7;
    localparam logic [SHORT_W-1:0] LONG_SLOT_DEFAULT     = 8'd70;

    // Read-ROM sequence
    localparam logic [BYTE_W-1:0] ROM_CMD_BYTE = 8'h33;
    localparam int                ROM_BYTES    = 9;

    // Depth of the queue between front end and engine
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [LONG_W-1:0]  reset_low;
        logic [SHORT_W-1:0] presence_wait;
        logic [LONG_W-1:0]  reset_tail;
        logic [SHORT_W-1:0] short_slot;
        logic [SHORT_W-1:0] long_slot;
    } cfg_t;

    // Classified item: op is the command with spare codes folded to a tick
    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic              is_start;
        logic              line_level;
        logic [BYTE_W-1:0] tx_byte;
        logic              pullup_on;
    } item_t;

    typedef struct packed {
        logic               drive_low;
        logic               drive_high;
        logic               busy_res;
        logic               done_res;
        logic               present;
        logic [BYTE_W-1:0]  rx_byte;
        logic               rx_valid;
        logic [INDEX_W-1:0] rx_index;
        logic               rejected;
    } res_t;

endpackage

>>> rtl/owm_if.sv
// ----------------------------------------------------------------------------
// owm_if: channel interfaces of the 1-Wire bus master
// Command channel (tick items with bus level) and result channel, each with
// a valid/ready handshake and source/sink views.
// ----------------------------------------------------------------------------
interface owm_cmd_if import owm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic              line_level;
    logic [BYTE_W-1:0] tx_byte;
    logic              pullup_on;

    modport source (output valid, cmd, line_level, tx_byte, pullup_on, input ready);
    modport sink   (input valid, cmd, line_level, tx_byte, pullup_on, output ready);
endinterface

interface owm_res_if import owm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic               drive_high;
    logic               busy_res;
    logic               done_res;
    logic               present;
    logic [BYTE_W-1:0]  rx_byte;
    logic               rx_valid;
    logic [INDEX_W-1:0] rx_index;
    logic               rejected;

    modport source (output valid, drive_low, drive_high, busy_res, done_res, present,
                    rx_byte, rx_valid, rx_index, rejected, input ready);
    modport sink   (input valid, drive_low, drive_high, busy_res, done_res, present,
                    rx_byte, rx_valid, rx_index, rejected, output ready);
endinterface

>>> rtl/owm_front.sv
// ----------------------------------------------------------------------------
// owm_front: input stage of the 1-Wire bus master
// Accept command transactions, fold spare codes to ticks, flag start commands
// and hold the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module owm_front import owm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    owm_cmd_if.sink     cmd_chan,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;
    logic  push;

    assign push           = valid_reg && item_ready;
    assign cmd_chan.ready = !valid_reg || item_ready;
    assign accept         = cmd_chan.valid && cmd_chan.ready;

    always_comb
    begin
        item_next            = item_reg;
        item_next.line_level = cmd_chan.line_level;
        item_next.tx_byte    = cmd_chan.tx_byte;
        item_next.pullup_on  = cmd_chan.pullup_on;
        unique case (cmd_chan.cmd) inside
            CMD_RESET, CMD_WRITE, CMD_READ, CMD_ROM, CMD_PULLUP:
            begin
                item_next.op       = cmd_chan.cmd;
                item_next.is_start = 1'b1;
            end
            default:
            begin
                item_next.op       = CMD_TICK;
                item_next.is_start = 1'b0;
            end
        endcase
        if (!accept)
        begin
            item_next = item_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/owm_queue.sv
// ----------------------------------------------------------------------------
// owm_queue: short item queue between front end and engine
// Circular buffer of classified items; push when not full, pop on request.
// ----------------------------------------------------------------------------
module owm_queue import owm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    input  item_t push_item,
    output logic  push_ready,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule

>>> rtl/owm_engine.sv
// ----------------------------------------------------------------------------
// owm_engine: bus sequencing engine of the 1-Wire master
// Step the reset, slot and read-ROM sequences by one tick per item and
// register one result per item.
// ----------------------------------------------------------------------------
module owm_engine import owm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_pop,
    owm_res_if.source   res_chan
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_TAIL = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_REL   = 4'd5;
    localparam logic [3:0] PH_RD_LOW   = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_REC   = 4'd8;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_RESET = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_ROM   = 3'd4;

    localparam logic [INDEX_W:0] ROM_LIMIT = (INDEX_W + 1)'(ROM_BYTES);

    logic [3:0]         phase_reg,    phase_next;
    logic [LONG_W-1:0]  tick_reg,     tick_next;
    logic [2:0]         bit_reg,      bit_next;
    logic [BYTE_W-1:0]  shift_reg,    shift_next;
    logic [INDEX_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic               seen_reg,     seen_next;
    logic               pullup_reg,   pullup_next;
    logic [2:0]         kind_reg,     kind_next;
    logic               out_valid_reg;
    res_t               res_reg;
    res_t               res_next;

    logic [LONG_W-1:0]  len;
    logic [LONG_W-1:0]  len_eff;
    logic [LONG_W-1:0]  tick_inc;
    logic               over;
    logic               adv;

    assign adv      = item_valid && (!out_valid_reg || res_chan.ready);
    assign item_pop = adv;

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        byte_cnt_next = byte_cnt_reg;
        seen_next     = seen_reg;
        pullup_next   = pullup_reg;
        kind_next     = kind_reg;
        res_next      = '0;
        len           = '0;

        // Start or reject
        if (item.is_start && phase_reg != PH_IDLE)
        begin
            res_next.rejected = 1'b1;
        end
        else if (item.is_start)
        begin
            tick_next = '0;
            bit_next  = '0;
            if (item.op == CMD_PULLUP)
            begin
                pullup_next       = item.pullup_on;
                res_next.done_res = 1'b1;
            end
            else
            begin
                pullup_next = 1'b0;
                if (item.op == CMD_RESET || item.op == CMD_ROM)
                begin
                    kind_next     = (item.op == CMD_RESET) ? KIND_RESET : KIND_ROM;
                    seen_next     = 1'b0;
                    byte_cnt_next = '0;
                    if (!item.line_level)
                    begin
                        res_next.done_res = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RST_LOW;
                    end
                end
                else if (item.op == CMD_WRITE)
                begin
                    kind_next  = KIND_WRITE;
                    shift_next = item.tx_byte;
                    phase_next = PH_WR_LOW;
                end
                else
                begin
                    kind_next  = KIND_READ;
                    shift_next = '0;
                    phase_next = PH_RD_LOW;
                end
            end
        end

        // Length of the current phase
        unique case (phase_next) inside
            PH_RST_LOW:  len = cfg.reset_low;
            PH_RST_WAIT: len = LONG_W'(cfg.presence_wait);
            PH_RST_TAIL: len = cfg.reset_tail;
            PH_WR_LOW:   len = LONG_W'(shift_next[0] ? cfg.short_slot : cfg.long_slot);
            PH_WR_REL:   len = LONG_W'(shift_next[0] ? cfg.long_slot : cfg.short_slot);
            PH_RD_LOW,
            PH_RD_WAIT:  len = LONG_W'(cfg.short_slot);
            PH_RD_REC:   len = LONG_W'(cfg.long_slot);
            default:     len = '0;
        endcase
        len_eff  = (len == '0) ? LONG_W'(1) : len;
        tick_inc = tick_next + 1'b1;
        over     = (tick_inc >= len_eff);
        if (phase_next != PH_IDLE && phase_next <= PH_RD_REC)
        begin
            tick_next = over ? '0 : tick_inc;
        end

        // Advance the sequence by one tick
        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_RST_LOW:
            begin
                res_next.drive_low = 1'b1;
                if (over)
                begin
                    phase_next = PH_RST_WAIT;
                end
            end
            PH_RST_WAIT:
            begin
                if (over)
                begin
                    seen_next  = !item.line_level;
                    phase_next = PH_RST_TAIL;
                end
            end
            PH_RST_TAIL:
            begin
                if (over)
                begin
                    if (kind_next == KIND_ROM && seen_next)
                    begin
                        shift_next = ROM_CMD_BYTE;
                        bit_next   = '0;
                        phase_next = PH_WR_LOW;
                    end
                    else
                    begin
                        res_next.done_res = 1'b1;
                        res_next.present  = seen_next;
                        phase_next        = PH_IDLE;
                    end
                end
            end
            PH_WR_LOW:
            begin
                res_next.drive_low = 1'b1;
                if (over)
                begin
                    phase_next = PH_WR_REL;
                end
            end
            PH_WR_REL:
            begin
                if (over)
                begin
                    shift_next = shift_next >> 1;
                    if (bit_next == 3'd7)
                    begin
                        bit_next = '0;
                        if (kind_next == KIND_ROM)
                        begin
                            shift_next    = '0;
                            byte_cnt_next = '0;
                            phase_next    = PH_RD_LOW;
                        end
                        else
                        begin
                            res_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                        end
                    end
                    else
                    begin
                        bit_next   = bit_next + 1'b1;
                        phase_next = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW:
            begin
                res_next.drive_low = 1'b1;
                if (over)
                begin
                    phase_next = PH_RD_WAIT;
                end
            end
            PH_RD_WAIT:
            begin
                if (over)
                begin
                    shift_next = {item.line_level, shift_next[BYTE_W-1:1]};
                    phase_next = PH_RD_REC;
                end
            end
            PH_RD_REC:
            begin
                if (over)
                begin
                    if (bit_next == 3'd7)
                    begin
                        bit_next          = '0;
                        res_next.rx_valid = 1'b1;
                        res_next.rx_byte  = shift_next;
                        if (kind_next == KIND_ROM)
                        begin
                            res_next.rx_index = byte_cnt_next;
                            if (({1'b0, byte_cnt_next} + 1'b1) < ROM_LIMIT)
                            begin
                                byte_cnt_next = byte_cnt_next + 1'b1;
                                shift_next    = '0;
                                phase_next    = PH_RD_LOW;
                            end
                            else
                            begin
                                res_next.done_res = 1'b1;
                                res_next.present  = seen_next;
                                phase_next        = PH_IDLE;
                            end
                        end
                        else
                        begin
                            res_next.done_res = 1'b1;
                            phase_next        = PH_IDLE;
                        end
                    end
                    else
                    begin
                        bit_next   = bit_next + 1'b1;
                        phase_next = PH_RD_LOW;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res_next.drive_high = pullup_next;
        res_next.busy_res   = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            byte_cnt_reg  <= '0;
            seen_reg      <= 1'b0;
            pullup_reg    <= 1'b0;
            kind_reg      <= KIND_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                phase_reg    <= phase_next;
                tick_reg     <= tick_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                byte_cnt_reg <= byte_cnt_next;
                seen_reg     <= seen_next;
                pullup_reg   <= pullup_next;
                kind_reg     <= kind_next;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_chan.valid      = out_valid_reg;
    assign res_chan.drive_low  = res_reg.drive_low;
    assign res_chan.drive_high = res_reg.drive_high;
    assign res_chan.busy_res   = res_reg.busy_res;
    assign res_chan.done_res   = res_reg.done_res;
    assign res_chan.present    = res_reg.present;
    assign res_chan.rx_byte    = res_reg.rx_byte;
    assign res_chan.rx_valid   = res_reg.rx_valid;
    assign res_chan.rx_index   = res_reg.rx_index;
    assign res_chan.rejected   = res_reg.rejected;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.done_res && res_reg.busy_res))
        else $error("result reports done while still busy");

    a_rx_from_recovery: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res_next.rx_valid |-> phase_reg == PH_RD_REC)
        else $error("byte completed outside read recovery");

    a_idle_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> bit_reg == '0)
        else $error("bit counter left set in idle");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res_next.rejected |=> out_valid_reg && $past(phase_reg) != PH_IDLE)
        else $error("start rejected while idle");
`endif

endmodule

>>> rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master paced by microsecond tick items
// Runs reset/presence, byte write, byte read, read-ROM and strong pullup
// sequences; one result transaction per command transaction.
// ----------------------------------------------------------------------------
//
//  Channel    Dir   Handshake     Payload
//  cmd_chan   in    valid/ready   cmd, line_level, tx_byte, pullup_on
//  res_chan   out   valid/ready   drive_low, drive_high, busy_res, done_res,
//                                 present, rx_byte, rx_valid, rx_index, rejected
//  cfg        in    cfg_we        cfg_index, cfg_data (no read-back)
//
//  One transaction per cycle sustained while results are taken; each command
//  passes the front register, the queue and the engine result register.
//  The engine's per-tick counter update and compare sets the cycle budget.
//  Reset loads the timing registers with their defaults and idles the engine;
//  there is no clearing pass.
//  A stalled result holds in the engine's output register while the queue and
//  the front register keep taking command transactions until full.
//
module one_wire_bus_master import owm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    owm_cmd_if.sink             cmd_chan,
    owm_res_if.source           res_chan,
    input  logic                cfg_we,
    input  logic [REGIDX_W-1:0] cfg_index,
    input  logic [LONG_W-1:0]   cfg_data
);

    // Timing registers
    cfg_t  cfg_reg;
    cfg_t  cfg_next;

    // Front end to queue
    logic  front_valid;
    item_t front_item;
    logic  front_ready;

    // Queue to engine
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    // Decode configuration writes; indexes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESET_LOW:     cfg_next.reset_low     = cfg_data;
                REG_PRESENCE_WAIT: cfg_next.presence_wait = cfg_data[SHORT_W-1:0];
                REG_RESET_TAIL:    cfg_next.reset_tail    = cfg_data;
                REG_SHORT_SLOT:    cfg_next.short_slot    = cfg_data[SHORT_W-1:0];
                REG_LONG_SLOT:     cfg_next.long_slot     = cfg_data[SHORT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low     <= RESET_LOW_DEFAULT;
            cfg_reg.presence_wait <= PRESENCE_WAIT_DEFAULT;
            cfg_reg.reset_tail    <= RESET_TAIL_DEFAULT;
            cfg_reg.short_slot    <= SHORT_SLOT_DEFAULT;
            cfg_reg.long_slot     <= LONG_SLOT_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and classify command transactions
    owm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_chan   (cmd_chan),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    // Decouple the front end from the engine
    owm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    // Step the bus sequence one tick per item and register the result
    owm_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .res_chan   (res_chan)
    );

endmodule

>>> sim/tb_one_wire_bus_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master: self-checking bench for the 1-Wire bus master
// Feeds tick transactions carrying the sampled bus level: resets with and
// without presence, byte writes and reads, read-ROM and strong pullup, with
// stray commands sent while busy. A local model of the master predicts one
// result per tick, and every result transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
    import owm_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int DRAIN_CYCLES = 8;     // margin after the last result is back
    localparam int HOLD_CYCLES  = 80;    // long result back-pressure stretch
    localparam int STALL_LIMIT  = 2000;  // cycles without any transaction

    // Commands the block treats as plain ticks
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // Bus level pattern during the ticks of a sequence
    localparam int LINE_LOW    = 0;
    localparam int LINE_HIGH   = 1;
    localparam int LINE_RANDOM = 2;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_RST_LOW,
        BUS_RST_WAIT,
        BUS_RST_TAIL,
        BUS_WR_LOW,
        BUS_WR_REL,
        BUS_RD_LOW,
        BUS_RD_WAIT,
        BUS_RD_REC
    } bus_phase_e;

    typedef enum logic [2:0] {
        SEQ_NONE,
        SEQ_RESET,
        SEQ_WRITE,
        SEQ_READ,
        SEQ_ROM
    } seq_kind_e;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              line_level;
        logic [BYTE_W-1:0] tx_byte;
        logic              pullup_on;
    } bus_item_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                cfg_we;
    logic [REGIDX_W-1:0] cfg_index;
    logic [LONG_W-1:0]   cfg_data;

    owm_cmd_if cmd_chan ();
    owm_res_if res_chan ();

    one_wire_bus_master uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_chan  (cmd_chan),
        .res_chan  (res_chan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Bus master model: timing copy and sequencing state
    // ------------------------------------------------------------------------
    logic [LONG_W-1:0]  cf_reset_low     = RESET_LOW_DEFAULT;
    logic [SHORT_W-1:0] cf_presence_wait = PRESENCE_WAIT_DEFAULT;
    logic [LONG_W-1:0]  cf_reset_tail    = RESET_TAIL_DEFAULT;
    logic [SHORT_W-1:0] cf_short         = SHORT_SLOT_DEFAULT;
    logic [SHORT_W-1:0] cf_long          = LONG_SLOT_DEFAULT;

    bus_phase_e        bm_phase    = BUS_IDLE;
    seq_kind_e         bm_kind     = SEQ_NONE;
    logic [LONG_W-1:0] bm_ticks    = '0;
    logic [2:0]        bm_bits     = '0;
    logic [BYTE_W-1:0] bm_shift    = '0;
    logic [3:0]        bm_bytes    = '0;
    logic              bm_presence = 1'b0;
    logic              bm_pullup   = 1'b0;

    bus_item_t ticks_to_send[$];
    res_t      bus_results_due[$];

    int error_count     = 0;
    int results_checked = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int stall_asked     = 0;
    int stall_taken     = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;

    // Advance the phase counter by one tick; a zero length counts as one tick
    function automatic logic slot_over(input logic [LONG_W-1:0] len);
        logic [LONG_W-1:0] span;
        span = (len == '0) ? LONG_W'(1) : len;
        bm_ticks = bm_ticks + LONG_W'(1);
        if (bm_ticks >= span)
        begin
            bm_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the result of one tick transaction and advance the model
    task automatic advance_bus(input bus_item_t it, output res_t r);
        logic is_start;
        is_start = (it.cmd >= CMD_RESET) && (it.cmd <= CMD_PULLUP);
        r = '0;

        if (is_start && bm_phase != BUS_IDLE)
            r.rejected = 1'b1;
        else if (is_start)
        begin
            bm_ticks = '0;
            bm_bits  = '0;
            if (it.cmd == CMD_PULLUP)
            begin
                bm_pullup  = it.pullup_on;
                r.done_res = 1'b1;
            end
            else
            begin
                // any real sequence drops the strong pullup
                bm_pullup = 1'b0;
                if (it.cmd == CMD_RESET || it.cmd == CMD_ROM)
                begin
                    bm_kind     = (it.cmd == CMD_RESET) ? SEQ_RESET : SEQ_ROM;
                    bm_presence = 1'b0;
                    bm_bytes    = '0;
                    if (!it.line_level)
                        r.done_res = 1'b1;   // bus already held low
                    else
                        bm_phase = BUS_RST_LOW;
                end
                else if (it.cmd == CMD_WRITE)
                begin
                    bm_kind  = SEQ_WRITE;
                    bm_shift = it.tx_byte;
                    bm_phase = BUS_WR_LOW;
                end
                else
                begin
                    bm_kind  = SEQ_READ;
                    bm_shift = '0;
                    bm_phase = BUS_RD_LOW;
                end
            end
        end

        // the start item is also the first tick of its sequence
        case (bm_phase)
            BUS_RST_LOW:
            begin
                r.drive_low = 1'b1;
                if (slot_over(cf_reset_low))
                    bm_phase = BUS_RST_WAIT;
            end
            BUS_RST_WAIT:
            begin
                if (slot_over(LONG_W'(cf_presence_wait)))
                begin
                    bm_presence = ~it.line_level;
                    bm_phase    = BUS_RST_TAIL;
                end
            end
            BUS_RST_TAIL:
            begin
                if (slot_over(cf_reset_tail))
                begin
                    if (bm_kind == SEQ_ROM && bm_presence)
                    begin
                        bm_shift = ROM_CMD_BYTE;
                        bm_bits  = '0;
                        bm_phase = BUS_WR_LOW;
                    end
                    else
                    begin
                        r.done_res = 1'b1;
                        r.present  = bm_presence;
                        bm_phase   = BUS_IDLE;
                    end
                end
            end
            BUS_WR_LOW:
            begin
                r.drive_low = 1'b1;
                if (slot_over(bm_shift[0] ? LONG_W'(cf_short) : LONG_W'(cf_long)))
                    bm_phase = BUS_WR_REL;
            end
            BUS_WR_REL:
            begin
                if (slot_over(bm_shift[0] ? LONG_W'(cf_long) : LONG_W'(cf_short)))
                begin
                    bm_shift = bm_shift >> 1;
                    if (bm_bits == 3'd7)
                    begin
                        bm_bits = '0;
                        if (bm_kind == SEQ_ROM)
                        begin
                            bm_shift = '0;
                            bm_bytes = '0;
                            bm_phase = BUS_RD_LOW;
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            bm_phase   = BUS_IDLE;
                        end
                    end
                    else
                    begin
                        bm_bits  = bm_bits + 3'd1;
                        bm_phase = BUS_WR_LOW;
                    end
                end
            end
            BUS_RD_LOW:
            begin
                r.drive_low = 1'b1;
                if (slot_over(LONG_W'(cf_short)))
                    bm_phase = BUS_RD_WAIT;
            end
            BUS_RD_WAIT:
            begin
                if (slot_over(LONG_W'(cf_short)))
                begin
                    bm_shift = {it.line_level, bm_shift[BYTE_W-1:1]};
                    bm_phase = BUS_RD_REC;
                end
            end
            BUS_RD_REC:
            begin
                if (slot_over(LONG_W'(cf_long)))
                begin
                    if (bm_bits == 3'd7)
                    begin
                        bm_bits    = '0;
                        r.rx_valid = 1'b1;
                        r.rx_byte  = bm_shift;
                        if (bm_kind == SEQ_ROM)
                        begin
                            r.rx_index = bm_bytes;
                            if (int'(bm_bytes) + 1 < ROM_BYTES)
                            begin
                                bm_bytes = bm_bytes + 4'd1;
                                bm_shift = '0;
                                bm_phase = BUS_RD_LOW;
                            end
                            else
                            begin
                                r.done_res = 1'b1;
                                r.present  = bm_presence;
                                bm_phase   = BUS_IDLE;
                            end
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            bm_phase   = BUS_IDLE;
                        end
                    end
                    else
                    begin
                        bm_bits  = bm_bits + 3'd1;
                        bm_phase = BUS_RD_LOW;
                    end
                end
            end
            default:
                bm_phase = BUS_IDLE;
        endcase

        r.drive_high = bm_pullup;
        r.busy_res   = (bm_phase != BUS_IDLE);
    endtask

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        error_count++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_checked, what, got_v, want_v);
    endtask

    task automatic check_field(input string what, input logic [BYTE_W-1:0] got_v,
                               input logic [BYTE_W-1:0] want_v);
        if (got_v !== want_v)
            report_mismatch(what, int'(got_v), int'(want_v));
    endtask

    // ------------------------------------------------------------------------
    // Command driver: hold valid and payload until the transaction is taken,
    // predict the result of every accepted tick
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_item_t sent;
        bus_item_t next;
        res_t      due;
        if (!rst_n)
            cmd_chan.valid <= 1'b0;
        else
        begin
            if (cmd_chan.valid && cmd_chan.ready)
            begin
                sent.cmd        = cmd_chan.cmd;
                sent.line_level = cmd_chan.line_level;
                sent.tx_byte    = cmd_chan.tx_byte;
                sent.pullup_on  = cmd_chan.pullup_on;
                advance_bus(sent, due);
                bus_results_due.push_back(due);
            end
            // only move on once the current transaction has gone
            if (!cmd_chan.valid || cmd_chan.ready)
            begin
                if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next = ticks_to_send.pop_front();
                    cmd_chan.cmd        <= next.cmd;
                    cmd_chan.line_level <= next.line_level;
                    cmd_chan.tx_byte    <= next.tx_byte;
                    cmd_chan.pullup_on  <= next.pullup_on;
                    cmd_chan.valid      <= 1'b1;
                end
                else
                    cmd_chan.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random back-pressure, plus a long hold when asked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            res_chan.ready <= 1'b0;
        else if (stall_asked != stall_taken)
        begin
            stall_taken = stall_asked;
            hold_left   = HOLD_CYCLES;
            res_chan.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_chan.ready <= 1'b0;
        end
        else
            res_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each result transaction with the oldest
    // prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_chan.valid && res_chan.ready)
        begin
            if (bus_results_due.size() == 0)
                report_mismatch("result with none outstanding", 1, 0);
            else
            begin
                want = bus_results_due.pop_front();
                check_field("drive_low",  BYTE_W'(res_chan.drive_low),  BYTE_W'(want.drive_low));
                check_field("drive_high", BYTE_W'(res_chan.drive_high), BYTE_W'(want.drive_high));
                check_field("busy_res",   BYTE_W'(res_chan.busy_res),   BYTE_W'(want.busy_res));
                check_field("done_res",   BYTE_W'(res_chan.done_res),   BYTE_W'(want.done_res));
                check_field("present",    BYTE_W'(res_chan.present),    BYTE_W'(want.present));
                check_field("rx_byte",    res_chan.rx_byte,             want.rx_byte);
                check_field("rx_valid",   BYTE_W'(res_chan.rx_valid),   BYTE_W'(want.rx_valid));
                check_field("rx_index",   BYTE_W'(res_chan.rx_index),   BYTE_W'(want.rx_index));
                check_field("rejected",   BYTE_W'(res_chan.rejected),   BYTE_W'(want.rejected));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up when no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_chan.valid && cmd_chan.ready) || (res_chan.valid && res_chan.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int span_of(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // Wait until every tick has gone in and every result has come back
    task automatic wait_drained();
        while (ticks_to_send.size() != 0 || cmd_chan.valid || bus_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one timing register and update the model's copy with it
    task automatic write_reg(input logic [REGIDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= LONG_W'(value);
        case (idx)
            REG_RESET_LOW:     cf_reset_low     = LONG_W'(value);
            REG_PRESENCE_WAIT: cf_presence_wait = SHORT_W'(value);
            REG_RESET_TAIL:    cf_reset_tail    = LONG_W'(value);
            REG_SHORT_SLOT:    cf_short         = SHORT_W'(value);
            REG_LONG_SLOT:     cf_long          = SHORT_W'(value);
            default:           ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_timing(input int rst_low, input int pres_wait, input int rst_tail,
                                input int slot_short, input int slot_long);
        write_reg(REG_RESET_LOW,     rst_low);
        write_reg(REG_PRESENCE_WAIT, pres_wait);
        write_reg(REG_RESET_TAIL,    rst_tail);
        write_reg(REG_SHORT_SLOT,    slot_short);
        write_reg(REG_LONG_SLOT,     slot_long);
    endtask

    // Short timings keep sequences to a few dozen ticks
    task automatic pick_small_timing();
        apply_timing($urandom_range(8, 1), $urandom_range(4, 1), $urandom_range(8, 1),
                     $urandom_range(3, 1), $urandom_range(4, 1));
    endtask

    task automatic push_filler();
        bus_item_t it;
        case ($urandom_range(2))
            0:       it.cmd = CMD_SPARE_A;
            1:       it.cmd = CMD_SPARE_B;
            default: it.cmd = CMD_TICK;
        endcase
        it.line_level = 1'($urandom_range(1));
        it.tx_byte    = BYTE_W'($urandom);
        it.pullup_on  = 1'($urandom_range(1));
        ticks_to_send.push_back(it);
    endtask

    // Queue a start transaction followed by just enough ticks to finish it.
    // Stray start commands sprinkled into the ticks must be rejected.
    task automatic run_sequence(input logic [CMD_W-1:0] op, input logic start_line,
                                input logic presence, input logic [BYTE_W-1:0] txb,
                                input logic pon, input int line_mode, input int reject_pct);
        bus_item_t it;
        int        n;
        int        sample_at;
        int        slot_s;
        int        slot_l;
        int        roll;
        slot_s    = span_of(int'(cf_short));
        slot_l    = span_of(int'(cf_long));
        sample_at = 0;
        case (op) inside
            CMD_RESET, CMD_ROM:
            begin
                if (!start_line)
                    n = 1;
                else
                begin
                    sample_at = span_of(int'(cf_reset_low)) + span_of(int'(cf_presence_wait));
                    n = sample_at + span_of(int'(cf_reset_tail));
                    if (op == CMD_ROM && presence)
                        n += 8 * (slot_s + slot_l) + ROM_BYTES * 8 * (2 * slot_s + slot_l);
                end
            end
            CMD_WRITE: n = 8 * (slot_s + slot_l);
            CMD_READ:  n = 8 * (2 * slot_s + slot_l);
            default:   n = 1;
        endcase

        it.cmd        = op;
        it.line_level = start_line;
        it.tx_byte    = txb;
        it.pullup_on  = pon;
        ticks_to_send.push_back(it);

        for (int i = 2; i <= n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < reject_pct)
                it.cmd = CMD_W'($urandom_range(CMD_PULLUP, CMD_RESET));
            else if (roll < reject_pct + 3)
                it.cmd = CMD_SPARE_B;
            else
                it.cmd = CMD_TICK;
            case (line_mode)
                LINE_LOW:  it.line_level = 1'b0;
                LINE_HIGH: it.line_level = 1'b1;
                default:   it.line_level = 1'($urandom_range(1));
            endcase
            // a device answers by pulling the line low at the presence sample
            if (i == sample_at)
                it.line_level = ~presence;
            it.tx_byte   = BYTE_W'($urandom);
            it.pullup_on = 1'($urandom_range(1));
            ticks_to_send.push_back(it);
        end
    endtask

    task automatic run_random_sequence(input int reject_pct);
        int pick;
        int gap;
        pick = $urandom_range(99);
        gap  = $urandom_range(2);
        if (pick < 25)
            run_sequence(CMD_RESET, $urandom_range(99) < 85, 1'($urandom_range(1)),
                         BYTE_W'($urandom), 1'($urandom_range(1)), LINE_RANDOM, reject_pct);
        else if (pick < 50)
            run_sequence(CMD_WRITE, 1'($urandom_range(1)), 1'b0, BYTE_W'($urandom),
                         1'($urandom_range(1)), LINE_RANDOM, reject_pct);
        else if (pick < 70)
            run_sequence(CMD_READ, 1'($urandom_range(1)), 1'b0, BYTE_W'($urandom),
                         1'($urandom_range(1)), LINE_RANDOM, reject_pct);
        else if (pick < 80)
            // no device answers here: nine byte reads would swamp the run
            run_sequence(CMD_ROM, $urandom_range(99) < 85, 1'b0,
                         BYTE_W'($urandom), 1'($urandom_range(1)), LINE_RANDOM, reject_pct);
        else if (pick < 90)
            run_sequence(CMD_PULLUP, 1'($urandom_range(1)), 1'b0, BYTE_W'($urandom),
                         1'($urandom_range(1)), LINE_RANDOM, reject_pct);
        else
            gap = $urandom_range(4, 1);   // bare ticks and spare codes only
        repeat (gap) push_filler();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cmd_chan.valid      = 1'b0;
        cmd_chan.cmd        = CMD_TICK;
        cmd_chan.line_level = 1'b1;
        cmd_chan.tx_byte    = '0;
        cmd_chan.pullup_on  = 1'b0;
        res_chan.ready      = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_RESET_LOW;
        cfg_data            = '0;

        // sender idles lightly, receiver heavily
        send_idle_pct = 11;
        recv_idle_pct = 49;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in every timing register: each phase lasts a single tick,
        // which keeps a full read-ROM to a couple of hundred ticks
        apply_timing(0, 0, 0, 0, 0);
        push_filler();
        run_sequence(CMD_RESET,  1'b1, 1'b1, 8'h00, 1'b0, LINE_RANDOM, 0);
        run_sequence(CMD_RESET,  1'b1, 1'b0, 8'h00, 1'b0, LINE_RANDOM, 0);
        run_sequence(CMD_RESET,  1'b0, 1'b0, 8'h00, 1'b0, LINE_RANDOM, 0);
        run_sequence(CMD_ROM,    1'b1, 1'b1, 8'h00, 1'b0, LINE_RANDOM, 5);
        run_sequence(CMD_ROM,    1'b1, 1'b0, 8'h00, 1'b0, LINE_RANDOM, 0);
        run_sequence(CMD_ROM,    1'b0, 1'b1, 8'h00, 1'b0, LINE_RANDOM, 0);
        // pullup dropped by the next write, then by the next reset
        run_sequence(CMD_PULLUP, 1'b1, 1'b0, 8'h00, 1'b1, LINE_RANDOM, 0);
        run_sequence(CMD_WRITE,  1'b1, 1'b0, 8'hA5, 1'b1, LINE_RANDOM, 0);
        run_sequence(CMD_PULLUP, 1'b1, 1'b0, 8'h00, 1'b1, LINE_RANDOM, 0);
        run_sequence(CMD_RESET,  1'b1, 1'b1, 8'h00, 1'b1, LINE_RANDOM, 0);
        run_sequence(CMD_PULLUP, 1'b0, 1'b0, 8'h00, 1'b0, LINE_RANDOM, 0);
        push_filler();
        wait_drained();

        // Swap the idling: sender gaps heavy, receiver light
        send_idle_pct = 49;
        recv_idle_pct = 11;
        apply_timing(3, 2, 3, 1, 2);
        run_sequence(CMD_WRITE,  1'b1, 1'b0, 8'h96, 1'b0, LINE_RANDOM, 0);
        run_sequence(CMD_READ,   1'b1, 1'b0, 8'h00, 1'b0, LINE_RANDOM, 30);
        run_sequence(CMD_RESET,  1'b1, 1'b1, 8'h00, 1'b0, LINE_RANDOM, 5);
        wait_drained();

        // Long receiver hold while ticks keep coming: fill the block up
        pick_small_timing();
        stall_asked++;
        run_sequence(CMD_WRITE,  1'b1, 1'b0, 8'h3C, 1'b0, LINE_RANDOM, 5);
        repeat (2) run_random_sequence(5);
        // pause the sender until every outstanding result is back
        wait_drained();
        repeat (2) run_random_sequence(5);
        wait_drained();

        // No idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pick_small_timing();
        repeat (3) run_random_sequence(5);
        wait_drained();

        if (bus_results_due.size() != 0)
            report_mismatch("results outstanding at end", 0, bus_results_due.size());

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/owm_pkg.sv
rtl/owm_if.sv
rtl/owm_front.sv
rtl/owm_queue.sv
rtl/owm_engine.sv
rtl/one_wire_bus_master.sv
sim/tb_one_wire_bus_master.sv
